FILE: design/gtpdf_pkg.sv
// ----------------------------------------------------------------------------
// gtpdf_pkg: shared types and constants for the grid distance fill
// Holds the cell encoding, the controller/datapath command and status
// structs, and the 3x3 neighbor offset table.
// ----------------------------------------------------------------------------
package gtpdf_pkg;

	localparam int GRID_SIZE_DEF = 64;
	localparam int COORD_W       = 6;
	localparam int ROW_W         = 64;
	localparam int DIST_W        = 12;
	localparam int STAT_W        = 2;
	localparam int ENTRY_W       = STAT_W + DIST_W;
	localparam int NB_W          = 4;

	localparam logic [DIST_W-1:0] DIST_MAX  = '1;
	localparam logic [NB_W-1:0]   NB_CENTER = 4'd4;
	localparam logic [NB_W-1:0]   NB_LAST   = 4'd8;

	// Cell status codes, also stored in the top bits of each table entry.
	typedef enum logic [STAT_W-1:0] {
		ST_REACHED = 2'd0,
		ST_UNKNOWN = 2'd1,
		ST_BLOCKED = 2'd2
	} cell_stat_t;

	// Register indexes on the configuration port.
	localparam logic REG_TARGET_X = 1'b0;
	localparam logic REG_TARGET_Y = 1'b1;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic accept;
		logic out_load;
		logic init_start;
		logic init_rd;
		logic init_wr;
		logic seed_wr;
		logic rlx_rd;
		logic rlx_wr;
	} dp_cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic out_valid;
		logic is_read;
		logic build_req;
		logic row_end;
		logic grid_end;
		logic nb_last;
		logic pass_last;
		logic pass_bwd;
	} dp_stat_t;

	// Neighbor step to offsets: {dx+1, dy+1}, two bits each.
	function automatic logic [3:0] nb_offset(input logic [NB_W-1:0] nb);
		logic [3:0] off;
		case (nb)
			4'd0: off = {2'd0, 2'd0};
			4'd1: off = {2'd0, 2'd1};
			4'd2: off = {2'd0, 2'd2};
			4'd3: off = {2'd1, 2'd0};
			4'd4: off = {2'd1, 2'd1};
			4'd5: off = {2'd1, 2'd2};
			4'd6: off = {2'd2, 2'd0};
			4'd7: off = {2'd2, 2'd1};
			4'd8: off = {2'd2, 2'd2};
			default: off = {2'd1, 2'd1};
		endcase
		return off;
	endfunction

endpackage

FILE: design/gtpdf_dp.sv
// ----------------------------------------------------------------------------
// gtpdf_dp: datapath of the grid distance fill
// Obstacle row memory, distance table memory, cell and neighbor counters,
// the neighborhood minimum, target registers and the result register.
// ----------------------------------------------------------------------------
module gtpdf_dp #(
	parameter int GRID_SIZE = gtpdf_pkg::GRID_SIZE_DEF
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  gtpdf_pkg::dp_cmd_t                  cmd,
	output gtpdf_pkg::dp_stat_t                 stat,
	input  logic                                cfg_we,
	input  logic                                cfg_index,
	input  logic [gtpdf_pkg::COORD_W-1:0]       cfg_data,
	input  logic                                in_mode,
	input  logic                                in_last,
	input  logic [gtpdf_pkg::ROW_W-1:0]         row_bits,
	input  logic [gtpdf_pkg::COORD_W-1:0]       row_number,
	input  logic [gtpdf_pkg::COORD_W-1:0]       read_x,
	input  logic [gtpdf_pkg::COORD_W-1:0]       read_y,
	input  logic                                m_tready,
	output logic                                out_valid,
	output logic [gtpdf_pkg::STAT_W-1:0]        out_status,
	output logic [gtpdf_pkg::DIST_W-1:0]        out_dist
);

	localparam int CW    = $clog2(GRID_SIZE);
	localparam int AW    = $clog2(GRID_SIZE * GRID_SIZE);
	localparam int DEPTH = GRID_SIZE * GRID_SIZE;
	localparam int EW    = gtpdf_pkg::ENTRY_W;
	localparam int DW    = gtpdf_pkg::DIST_W;
	localparam int OW    = gtpdf_pkg::COORD_W + 1;

	localparam logic [CW-1:0] C_LAST = CW'(GRID_SIZE - 1);
	localparam logic [CW-1:0] C_HI   = CW'(GRID_SIZE - 2);
	localparam logic [CW-1:0] C_LO   = CW'(1);
	localparam logic [OW-1:0] G_LIM  = OW'(GRID_SIZE);

	function automatic logic [AW-1:0] cell_addr(input logic [CW-1:0] x,
		input logic [CW-1:0] y);
		return AW'(y) * AW'(GRID_SIZE) + AW'(x);
	endfunction

	logic [gtpdf_pkg::COORD_W-1:0] tgt_x_q, tgt_y_q;
	logic [gtpdf_pkg::ROW_W-1:0]   obs_mem [GRID_SIZE];
	logic [gtpdf_pkg::ROW_W-1:0]   obs_rd_q;
	logic [EW-1:0]                 dist_mem [DEPTH];
	logic [EW-1:0]                 rd_q;
	logic [CW-1:0]                 cx_q, cy_q;
	logic [gtpdf_pkg::NB_W-1:0]    nb_q;
	logic                          dir_q;
	logic [DW-1:0]                 acc_q;
	logic                          found_q, ctr_unk_q;
	logic                          rd_pend_s1, ctr_s1;
	logic                          oor_q, ready_q;
	logic                          out_valid_q;
	logic [gtpdf_pkg::STAT_W-1:0]  out_stat_q;
	logic [DW-1:0]                 out_dist_q;

	logic          row_in, rd_oor, seed_in, pass_last;
	logic [3:0]    off;
	logic [CW-1:0] nx, ny;
	logic [AW-1:0] rd_addr, wr_addr;
	logic          wr_en;
	logic [EW-1:0] wr_data;
	logic [DW-1:0] new_dist;
	logic [gtpdf_pkg::STAT_W-1:0] rd_stat;
	logic [DW-1:0] rd_dist;

	// Range checks on item and target coordinates.
	assign row_in  = {1'b0, row_number} < G_LIM;
	assign rd_oor  = ({1'b0, read_x} >= G_LIM) || ({1'b0, read_y} >= G_LIM);
	assign seed_in = ({1'b0, tgt_x_q} < G_LIM) && ({1'b0, tgt_y_q} < G_LIM);

	// Neighbor coordinates of the current interior cell.
	assign off = gtpdf_pkg::nb_offset(nb_q);
	assign nx  = cx_q + CW'(off[3:2]) - C_LO;
	assign ny  = cy_q + CW'(off[1:0]) - C_LO;

	assign pass_last = dir_q ? ((cx_q == C_LO) && (cy_q == C_LO))
	                         : ((cx_q == C_HI) && (cy_q == C_HI));

	assign rd_stat  = rd_q[EW-1:DW];
	assign rd_dist  = rd_q[DW-1:0];
	assign new_dist = (acc_q == gtpdf_pkg::DIST_MAX) ? acc_q : acc_q + DW'(1);

	// Table port selection.
	always_comb begin
		rd_addr = cmd.rlx_rd ? cell_addr(nx, ny)
		        : (rd_oor ? '0 : cell_addr(read_x[CW-1:0], read_y[CW-1:0]));
		wr_en   = 1'b0;
		wr_addr = cell_addr(cx_q, cy_q);
		wr_data = {gtpdf_pkg::ST_REACHED, new_dist};
		if (cmd.init_wr) begin
			wr_en   = 1'b1;
			wr_data = obs_rd_q[cx_q] ? {gtpdf_pkg::ST_BLOCKED, DW'(0)}
			                         : {gtpdf_pkg::ST_UNKNOWN, DW'(0)};
		end else if (cmd.seed_wr) begin
			wr_en   = seed_in;
			wr_addr = cell_addr(tgt_x_q[CW-1:0], tgt_y_q[CW-1:0]);
			wr_data = {gtpdf_pkg::ST_REACHED, DW'(0)};
		end else if (cmd.rlx_wr) begin
			wr_en   = ctr_unk_q && found_q;
		end
	end

	// Distance table memory.
	always_ff @(posedge clk) begin
		if (wr_en) begin
			dist_mem[wr_addr] <= wr_data;
		end
		if (cmd.rlx_rd || cmd.accept) begin
			rd_q <= dist_mem[rd_addr];
		end
	end

	// Obstacle row memory.
	always_ff @(posedge clk) begin
		if (cmd.accept && !in_mode && row_in) begin
			obs_mem[row_number[CW-1:0]] <= row_bits;
		end
		if (cmd.init_rd) begin
			obs_rd_q <= obs_mem[cy_q];
		end
	end

	// Target registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tgt_x_q <= '0;
			tgt_y_q <= '0;
		end else if (cfg_we) begin
			if (cfg_index == gtpdf_pkg::REG_TARGET_X) begin
				tgt_x_q <= cfg_data;
			end else begin
				tgt_y_q <= cfg_data;
			end
		end
	end

	// Cell and neighbor counters for the sweep and both passes.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cx_q  <= '0;
			cy_q  <= '0;
			nb_q  <= '0;
			dir_q <= 1'b0;
		end else begin
			if (cmd.init_start) begin
				cx_q <= '0;
				cy_q <= '0;
			end else if (cmd.init_wr) begin
				if (cx_q == C_LAST) begin
					cx_q <= '0;
					cy_q <= cy_q + C_LO;
				end else begin
					cx_q <= cx_q + C_LO;
				end
			end else if (cmd.seed_wr) begin
				cx_q  <= C_LO;
				cy_q  <= C_LO;
				dir_q <= 1'b0;
			end else if (cmd.rlx_wr) begin
				if (pass_last) begin
					cx_q  <= C_HI;
					cy_q  <= C_HI;
					dir_q <= 1'b1;
				end else if (!dir_q) begin
					if (cy_q == C_HI) begin
						cy_q <= C_LO;
						cx_q <= cx_q + C_LO;
					end else begin
						cy_q <= cy_q + C_LO;
					end
				end else begin
					if (cy_q == C_LO) begin
						cy_q <= C_HI;
						cx_q <= cx_q - C_LO;
					end else begin
						cy_q <= cy_q - C_LO;
					end
				end
			end
			if (cmd.seed_wr) begin
				nb_q <= '0;
			end else if (cmd.rlx_rd) begin
				nb_q <= (nb_q == gtpdf_pkg::NB_LAST) ? '0 : nb_q + 4'd1;
			end
		end
	end

	// Minimum over the reached neighbors, one read beat per cycle.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rd_pend_s1 <= 1'b0;
			ctr_s1     <= 1'b0;
			found_q    <= 1'b0;
			ctr_unk_q  <= 1'b0;
			acc_q      <= '0;
		end else begin
			rd_pend_s1 <= cmd.rlx_rd;
			ctr_s1     <= cmd.rlx_rd && (nb_q == gtpdf_pkg::NB_CENTER);
			if (cmd.rlx_rd && (nb_q == '0)) begin
				found_q <= 1'b0;
			end else if (rd_pend_s1) begin
				if ((rd_stat == gtpdf_pkg::ST_REACHED) && (!found_q || rd_dist < acc_q)) begin
					acc_q   <= rd_dist;
					found_q <= 1'b1;
				end
				if (ctr_s1) begin
					ctr_unk_q <= (rd_stat == gtpdf_pkg::ST_UNKNOWN);
				end
			end
		end
	end

	// Table-ready flag and the result register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ready_q     <= 1'b0;
			oor_q       <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.rlx_wr && pass_last && dir_q) begin
				ready_q <= 1'b1;
			end
			if (cmd.accept) begin
				oor_q <= rd_oor;
			end
			if (cmd.out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_valid_q && m_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.out_load) begin
			if (oor_q) begin
				out_stat_q <= gtpdf_pkg::ST_BLOCKED;
				out_dist_q <= '0;
			end else if (!ready_q) begin
				out_stat_q <= gtpdf_pkg::ST_REACHED;
				out_dist_q <= '0;
			end else begin
				out_stat_q <= rd_stat;
				out_dist_q <= rd_dist;
			end
		end
	end

	assign out_valid  = out_valid_q;
	assign out_status = out_stat_q;
	assign out_dist   = out_dist_q;

	assign stat.out_valid = out_valid_q;
	assign stat.is_read   = in_mode;
	assign stat.build_req = in_last;
	assign stat.row_end   = (cx_q == C_LAST);
	assign stat.grid_end  = (cx_q == C_LAST) && (cy_q == C_LAST);
	assign stat.nb_last   = (nb_q == gtpdf_pkg::NB_LAST);
	assign stat.pass_last = pass_last;
	assign stat.pass_bwd  = dir_q;

endmodule

FILE: design/gtpdf_ctrl.sv
// ----------------------------------------------------------------------------
// gtpdf_ctrl: controller of the grid distance fill
// Sequences item intake, the table rebuild sweep, the seed write and the
// forward and backward relaxation passes.
// ----------------------------------------------------------------------------
module gtpdf_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                s_tvalid,
	output logic                s_tready,
	input  logic                m_tready,
	input  gtpdf_pkg::dp_stat_t stat,
	output gtpdf_pkg::dp_cmd_t  cmd
);

	typedef enum logic [7:0] {
		S_IDLE     = 8'b0000_0001,
		S_RD_WAIT  = 8'b0000_0010,
		S_INIT_RD  = 8'b0000_0100,
		S_INIT_WR  = 8'b0000_1000,
		S_SEED     = 8'b0001_0000,
		S_RLX_RD   = 8'b0010_0000,
		S_RLX_WAIT = 8'b0100_0000,
		S_RLX_WR   = 8'b1000_0000
	} state_t;

	state_t state_q, state_d;
	logic   accept;

	// Take an item only while idle with the result register free or draining.
	assign s_tready = (state_q == S_IDLE) && (!stat.out_valid || m_tready);
	assign accept   = s_tvalid && s_tready;

	// Next state and command decode.
	always_comb begin
		state_d        = state_q;
		cmd            = '0;
		cmd.accept     = accept;
		case (state_q)
			S_IDLE: begin
				if (accept) begin
					if (stat.is_read) begin
						state_d = S_RD_WAIT;
					end else if (stat.build_req) begin
						cmd.init_start = 1'b1;
						state_d        = S_INIT_RD;
					end
				end
			end
			S_RD_WAIT: begin
				cmd.out_load = 1'b1;
				state_d      = S_IDLE;
			end
			S_INIT_RD: begin
				cmd.init_rd = 1'b1;
				state_d     = S_INIT_WR;
			end
			S_INIT_WR: begin
				cmd.init_wr = 1'b1;
				if (stat.grid_end) begin
					state_d = S_SEED;
				end else if (stat.row_end) begin
					state_d = S_INIT_RD;
				end
			end
			S_SEED: begin
				cmd.seed_wr = 1'b1;
				state_d     = S_RLX_RD;
			end
			S_RLX_RD: begin
				cmd.rlx_rd = 1'b1;
				if (stat.nb_last) begin
					state_d = S_RLX_WAIT;
				end
			end
			S_RLX_WAIT: begin
				state_d = S_RLX_WR;
			end
			S_RLX_WR: begin
				cmd.rlx_wr = 1'b1;
				state_d    = (stat.pass_last && stat.pass_bwd) ? S_IDLE : S_RLX_RD;
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	// State register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

endmodule

FILE: design/grid_two_pass_distance_fill.sv
// ----------------------------------------------------------------------------
// grid_two_pass_distance_fill: two-pass 8-neighbor grid distance fill
// Loads obstacle rows, rebuilds the distance table on the last row with a
// forward and a backward pass, and answers cell reads.
//
//   channel  | direction | fields
//   ---------+-----------+------------------------------------------------
//   s_*      | in        | tdata: row_bits, row_number, read_x, read_y;
//            |           | tuser: mode; tlast: last_row
//   m_*      | out       | tdata: cell_status, distance
//   cfg_*    | in        | index 0 target_x, index 1 target_y
//
// A read beat passes the table read register, then the result register.
// A last-row load starts a rebuild: a sweep, then a forward and a backward
// pass of nine neighbor reads, one wait and one write per interior cell on
// the single read port of the distance table. No beat is taken during a
// rebuild or while the result register is full and stalled. Reset clears
// control state; both memories hold no reset.
// ----------------------------------------------------------------------------
module grid_two_pass_distance_fill #(
	parameter int GRID_SIZE = gtpdf_pkg::GRID_SIZE_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [87:0] s_tdata,  // row_bits[63:0], row_number[69:64],
	                              // read_x[75:70], read_y[81:76], zero pad
	input  logic        s_tuser,  // mode
	input  logic        s_tlast,  // last_row
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [15:0] m_tdata,  // cell_status[1:0], distance[13:2], zero pad
	input  logic        cfg_we,
	input  logic        cfg_index,
	input  logic [5:0]  cfg_data
);

	gtpdf_pkg::dp_cmd_t  cmd;
	gtpdf_pkg::dp_stat_t stat;
	logic [gtpdf_pkg::STAT_W-1:0] out_status;
	logic [gtpdf_pkg::DIST_W-1:0] out_dist;

	gtpdf_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.m_tready (m_tready),
		.stat     (stat),
		.cmd      (cmd)
	);

	gtpdf_dp #(
		.GRID_SIZE (GRID_SIZE)
	) u_dp (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd        (cmd),
		.stat       (stat),
		.cfg_we     (cfg_we),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data),
		.in_mode    (s_tuser),
		.in_last    (s_tlast),
		.row_bits   (s_tdata[63:0]),
		.row_number (s_tdata[69:64]),
		.read_x     (s_tdata[75:70]),
		.read_y     (s_tdata[81:76]),
		.m_tready   (m_tready),
		.out_valid  (m_tvalid),
		.out_status (out_status),
		.out_dist   (out_dist)
	);

	assign m_tdata = {2'b00, out_dist, out_status};

	// A rebuild blocks intake on the cycle after the last row is taken.
	a_build_blocks: assert property (@(posedge clk) disable iff (!arst_n)
		(s_tvalid && s_tready && !s_tuser && s_tlast) |=> !s_tready)
		else $error("intake open right after a last-row load");

	// Every read beat raises m_tvalid once it has passed the table read register and the result register.
	a_read_result: assert property (@(posedge clk) disable iff (!arst_n)
		(s_tvalid && s_tready && s_tuser) |-> ##2 m_tvalid)
		else $error("read beat produced no result");

	// No read result appears without a read beat taken ahead of it through those registers.
	a_no_spurious: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(m_tvalid) |-> $past(s_tvalid && s_tready && s_tuser, 2))
		else $error("result appeared without a read beat");

endmodule

FILE: bench/tb_grid_two_pass_distance_fill.sv
// ----------------------------------------------------------------------------
// tb_grid_two_pass_distance_fill: self-checking bench for the grid distance fill
// Loads obstacle grids, rebuilds the distance table under several seed
// settings and checks every cell read against a built-in predictor, with
// random idling on the input stream and random stalls on the result stream.
// ----------------------------------------------------------------------------
module tb_grid_two_pass_distance_fill;

	import gtpdf_pkg::*;

	localparam int GRID        = GRID_SIZE_DEF;
	localparam int CELL_FREE   = -1;
	localparam int CELL_WALL   = -2;
	localparam int NO_BEST     = 999;
	localparam int CYCLE_LIMIT = 3000000;
	localparam int PHASES      = 6;

	typedef enum logic {
		OP_LOAD = 1'b0,
		OP_READ = 1'b1
	} op_t;

	typedef struct packed {
		op_t               mode;
		logic [ROW_W-1:0]  row_bits;
		logic [COORD_W-1:0] row_number;
		logic              last_row;
		logic [COORD_W-1:0] read_x;
		logic [COORD_W-1:0] read_y;
	} grid_beat_t;

	typedef struct packed {
		cell_stat_t        status;
		logic [DIST_W-1:0] dist_val;
	} cell_result_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [87:0] s_tdata = '0;  // row_bits, row_number, read_x, read_y, pad
	logic        s_tuser = 1'b0; // mode
	logic        s_tlast = 1'b0; // last_row
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [15:0] m_tdata;        // cell_status, distance, pad
	logic        cfg_we = 1'b0;
	logic        cfg_index = REG_TARGET_X;
	logic [5:0]  cfg_data = '0;

	grid_beat_t   pending_beats[$];
	cell_result_t expected_cells[$];
	grid_beat_t   cur_beat;

	// Predictor state: obstacle rows, distance table and seed registers.
	logic [ROW_W-1:0] obst_rows[GRID];
	int               dist_tab[GRID][GRID];
	logic [5:0]       seed_x = '0;
	logic [5:0]       seed_y = '0;

	int idle_pct = 0;
	int stall_pct = 0;
	int cycles = 0;
	int errors = 0;
	int n_loads = 0;
	int n_reads = 0;
	int n_builds = 0;

	grid_two_pass_distance_fill uut (
		.clk(clk), .arst_n(arst_n),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
		.s_tuser(s_tuser), .s_tlast(s_tlast),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	// Fill one unknown cell from its 3x3 neighborhood.
	function automatic void relax_cell(int x, int y);
		int best;
		int v;
		best = NO_BEST;
		if (dist_tab[y][x] != CELL_FREE) return;
		for (int dx = -1; dx <= 1; dx++)
			for (int dy = -1; dy <= 1; dy++) begin
				v = dist_tab[y+dy][x+dx];
				if (v >= 0 && v < best) best = v;
			end
		if (best != NO_BEST) dist_tab[y][x] = (best + 1 > 4095) ? 4095 : best + 1;
	endfunction

	// Rebuild the whole table: init, seed, forward pass, backward pass.
	function automatic void rebuild_table();
		for (int y = 0; y < GRID; y++)
			for (int x = 0; x < GRID; x++)
				dist_tab[y][x] = obst_rows[y][x] ? CELL_WALL : CELL_FREE;
		dist_tab[seed_y][seed_x] = 0;
		for (int x = 1; x < GRID - 1; x++)
			for (int y = 1; y < GRID - 1; y++)
				relax_cell(x, y);
		for (int x = GRID - 2; x > 0; x--)
			for (int y = GRID - 2; y > 0; y--)
				relax_cell(x, y);
		n_builds++;
	endfunction

	// Apply one accepted beat to the predictor.
	function automatic void predict_beat(grid_beat_t b);
		cell_result_t r;
		int v;
		if (b.mode == OP_LOAD) begin
			obst_rows[b.row_number] = b.row_bits;
			n_loads++;
			if (b.last_row) rebuild_table();
		end else begin
			v = dist_tab[b.read_y][b.read_x];
			r.dist_val = '0;
			if (v >= 0) begin
				r.status = ST_REACHED;
				r.dist_val = v[DIST_W-1:0];
			end else if (v == CELL_FREE) begin
				r.status = ST_UNKNOWN;
			end else begin
				r.status = ST_BLOCKED;
			end
			expected_cells.push_back(r);
			n_reads++;
		end
	endfunction

	task automatic report_mismatch(string what, int got, int want);
		$display("mismatch at cycle %0d: %s got %0d expected %0d", cycles, what, got, want);
		errors++;
	endtask

	// Input driver: present the next queued beat, idling at random.
	always @(posedge clk) begin
		if (arst_n) begin
			if (s_tvalid && s_tready) predict_beat(cur_beat);
			if (!s_tvalid || s_tready) begin
				if (pending_beats.size() != 0 && $urandom_range(99) >= idle_pct) begin
					cur_beat <= pending_beats[0];
					s_tdata <= {6'b0, pending_beats[0].read_y, pending_beats[0].read_x,
						pending_beats[0].row_number, pending_beats[0].row_bits};
					s_tuser <= pending_beats[0].mode;
					s_tlast <= pending_beats[0].last_row;
					s_tvalid <= 1'b1;
					pending_beats.pop_front();
				end else begin
					s_tvalid <= 1'b0;
				end
			end
		end
	end

	// Result monitor: random stalls, compare each beat with the oldest prediction.
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("timeout after %0d cycles", cycles);
			$display("[FAIL] regression broken");
			$finish;
		end else begin
			m_tready <= ($urandom_range(99) >= stall_pct);
			if (arst_n && m_tvalid && m_tready) begin
				if (expected_cells.size() == 0) begin
					report_mismatch("unexpected result, status", m_tdata[1:0], -1);
				end else begin
					if (m_tdata[1:0] != expected_cells[0].status)
						report_mismatch("cell_status", m_tdata[1:0], expected_cells[0].status);
					if (m_tdata[13:2] != expected_cells[0].dist_val)
						report_mismatch("distance", m_tdata[13:2], expected_cells[0].dist_val);
					expected_cells.pop_front();
				end
			end
		end
	end

	function automatic grid_beat_t load_beat(int row, logic [63:0] bits, logic last);
		grid_beat_t b;
		b.mode = OP_LOAD;
		b.row_bits = bits;
		b.row_number = row[5:0];
		b.last_row = last;
		b.read_x = COORD_W'($urandom());
		b.read_y = COORD_W'($urandom());
		return b;
	endfunction

	function automatic grid_beat_t read_beat(int x, int y);
		grid_beat_t b;
		b.mode = OP_READ;
		b.row_bits = {$urandom(), $urandom()};
		b.row_number = COORD_W'($urandom());
		b.last_row = 1'($urandom());
		b.read_x = x[5:0];
		b.read_y = y[5:0];
		return b;
	endfunction

	function automatic logic [63:0] sparse_row(int dense);
		logic [63:0] a;
		a = {$urandom(), $urandom()} & {$urandom(), $urandom()};
		if (!dense) a = a & {$urandom(), $urandom()};
		return a;
	endfunction

	// Wait until the block has nothing queued, in flight or owed.
	task automatic wait_drained();
		while (pending_beats.size() != 0 || s_tvalid || expected_cells.size() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic write_seed(int x, int y);
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_index <= REG_TARGET_X;
		cfg_data <= x[5:0];
		@(posedge clk);
		cfg_index <= REG_TARGET_Y;
		cfg_data <= y[5:0];
		@(posedge clk);
		cfg_we <= 1'b0;
		seed_x = x[5:0];
		seed_y = y[5:0];
	endtask

	// Random reads, with a few stray loads that only change the obstacle store.
	task automatic queue_reads(int count);
		int r;
		for (int i = 0; i < count; i++) begin
			if ($urandom_range(99) < 5) begin
				r = $urandom_range(GRID - 1);
				pending_beats.push_back(load_beat(r, sparse_row(0), 1'b0));
			end else begin
				pending_beats.push_back(read_beat($urandom_range(GRID - 1),
					$urandom_range(GRID - 1)));
			end
		end
	endtask

	initial begin
		int sx[PHASES];
		int sy[PHASES];
		int ip[PHASES];
		int sp[PHASES];
		int row;
		logic [63:0] bits;

		sx = '{0, 63, 32, 1, 62, 0};
		sy = '{0, 63, 31, 62, 1, 0};
		ip = '{0, 76, 0, 26, 0, 26};
		sp = '{0, 0, 76, 26, 0, 26};
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		sx[5] = $urandom_range(GRID - 1);
		sy[5] = $urandom_range(GRID - 1);

		for (int p = 0; p < PHASES; p++) begin
			wait_drained();
			write_seed(sx[p], sy[p]);
			idle_pct = ip[p];
			stall_pct = sp[p];
			if (p == 0) begin
				// Full grid: an empty row, a solid wall with one gap, a fully blocked last row, random rows.
				for (int r = 0; r < GRID; r++) begin
					if (r == 1) bits = '0;
					else if (r == 20) bits = ~(64'd1 << 40);
					else if (r == 63) bits = '1;
					else bits = sparse_row(0);
					pending_beats.push_back(load_beat(r, bits, r == GRID - 1));
				end
				// Corners (one of them the seed), the seed's neighbor and the gap in the wall.
				pending_beats.push_back(read_beat(0, 0));
				pending_beats.push_back(read_beat(63, 63));
				pending_beats.push_back(read_beat(0, 63));
				pending_beats.push_back(read_beat(63, 0));
				pending_beats.push_back(read_beat(1, 1));
				pending_beats.push_back(read_beat(40, 20));
			end else begin
				// Reload some rows; one phase puts an obstacle on the seed, another blocks row 30.
				for (int k = 0; k < 8; k++) begin
					row = (k == 7) ? sy[p] : $urandom_range(GRID - 1);
					bits = sparse_row(p == 3);
					if (p == 2 && k == 7) bits[sx[p]] = 1'b1;
					if (p == 4 && k == 0) begin
						row = 30;
						bits = '1;
					end
					pending_beats.push_back(load_beat(row, bits, k == 7));
				end
				pending_beats.push_back(read_beat(sx[p], sy[p]));
			end
			queue_reads(85);
			// Hold off until every owed result is back, then continue.
			wait_drained();
			queue_reads(85);
		end

		wait_drained();
		repeat (20) @(posedge clk);
		$display("covered %0d loads, %0d reads and %0d table rebuilds", n_loads, n_reads, n_builds);
		$display("across %0d seed settings with idle and stall mixes", PHASES);
		if (errors == 0) begin
			$display("[ OK ] regression clean");
		end else begin
			$display("%0d mismatches", errors);
			$display("[FAIL] regression broken");
		end
		$finish;
	end

endmodule

FILE: filelist.f
design/gtpdf_pkg.sv
design/gtpdf_dp.sv
design/gtpdf_ctrl.sv
design/grid_two_pass_distance_fill.sv
bench/tb_grid_two_pass_distance_fill.sv
